// ===== hdl/toy_isa_execute_unit_macros.svh =====
// Assertion macros for the toy ISA execute unit checker
`ifndef TOY_ISA_EXECUTE_UNIT_MACROS_SVH
`define TOY_ISA_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define TIEX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define TIEX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset
`define TIEX_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tiex_pkg.sv =====
// Shared types, codes and defaults for the toy ISA execute unit
package tiex_pkg;

  typedef logic [31:0] word_t;
  typedef logic [1:0]  status_t;
  typedef logic [3:0]  op_t;
  typedef logic [1:0]  kind_t;

  localparam int unsigned DEF_NUM_REGS  = 8;
  localparam int unsigned DEF_MEM_WORDS = 5;
  localparam int unsigned DEF_MEM_BASE  = 32'h0000_0100;

  localparam op_t OP_MOV   = 4'd0;
  localparam op_t OP_ADD   = 4'd1;
  localparam op_t OP_SUB   = 4'd2;
  localparam op_t OP_AND   = 4'd3;
  localparam op_t OP_OR    = 4'd4;
  localparam op_t OP_XOR   = 4'd5;
  localparam op_t OP_LOAD  = 4'd6;
  localparam op_t OP_STORE = 4'd7;
  localparam op_t OP_CMP   = 4'd8;
  localparam op_t OP_BEQ   = 4'd9;
  localparam op_t OP_BNE   = 4'd10;
  localparam op_t OP_BAL   = 4'd11;

  localparam kind_t KIND_REG = 2'd0;
  localparam kind_t KIND_IMM = 2'd1;
  localparam kind_t KIND_MEM = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_KIND = 2'd1;
  localparam status_t ST_BAD_ADDR = 2'd2;

endpackage

// ===== hdl/toy_isa_execute_unit.sv =====
// Toy ISA execute unit: register file, small data memory, zero flag and ALU
//
// Input channel (in_*): one decoded instruction per word, accepted when
// in_valid is high and in_stall is low. Result channel (out_*): one word per
// instruction, taken when out_valid is high and out_stall is low.
// A result passes the operand read register, then the result register,
// before it appears in out_*.
// Throughput: one instruction per cycle while in_stall is low;
// back-to-back dependencies are covered by forwarding the write of the
// retiring instruction into the operand read of the next one.
// Reset (rst_n low, synchronous): registers, memory words and zero flag read
// as zero, both pipeline stages empty.
// When out_stall holds the result, the operand stage still fills; once that
// stage is also full, in_stall rises until the result is taken. State only
// changes when an instruction moves into the result register.
// Errors (status nonzero) change no state and give zero value and no branch.
module toy_isa_execute_unit
  import tiex_pkg::*;
#(
  parameter int unsigned NUM_REGS  = DEF_NUM_REGS,
  parameter int unsigned MEM_WORDS = DEF_MEM_WORDS,
  parameter int unsigned MEM_BASE  = DEF_MEM_BASE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_operation,
  input  logic [2:0]  in_dest_reg,
  input  logic [2:0]  in_src_a_reg,
  input  logic [2:0]  in_src_b_reg,
  input  logic [1:0]  in_operand_kind,
  input  logic [31:0] in_immediate,
  input  logic [31:0] in_mem_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_result_value,
  output logic        out_zero_flag_out,
  output logic        out_branch_taken
);

  localparam int unsigned RIDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned MIDX_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  typedef logic [RIDX_W-1:0] ridx_t;
  typedef logic [MIDX_W-1:0] midx_t;

  function automatic ridx_t reg_wrap(input logic [2:0] field);
    ridx_t idx;
    idx = '0;
    for (int v = 0; v < 8; v++) begin
      if (field == 3'(v)) idx = RIDX_W'(v % NUM_REGS);
    end
    return idx;
  endfunction

  // storage
  word_t                rf_mem [NUM_REGS];
  logic  [NUM_REGS-1:0] rf_vld_r;
  word_t                dm_mem [MEM_WORDS];
  logic  [MEM_WORDS-1:0] dm_vld_r;
  logic                 zf_r;

  // operand stage
  logic    s1_vld_r;
  op_t     s1_op_r;
  ridx_t   s1_rd_r;
  kind_t   s1_kind_r;
  word_t   s1_imm_r;
  word_t   s1_addr_r;
  logic    s1_mok_r;
  midx_t   s1_midx_r;
  word_t   s1_a_r;
  word_t   s1_b_r;
  word_t   s1_m_r;

  // result stage
  logic    out_vld_r;
  status_t out_status_r;
  word_t   out_value_r;
  logic    out_zf_r;
  logic    out_taken_r;

  logic    s1_go;
  logic    in_go;
  ridx_t   ra_idx;
  ridx_t   rb_idx;
  word_t   addr_off;
  logic    mem_ok;
  midx_t   mem_idx;

  status_t ex_status;
  word_t   ex_value;
  logic    ex_taken;
  logic    ex_zf;
  logic    ex_rf_wr;
  logic    ex_dm_wr;
  word_t   ex_opb;
  word_t   ex_cmp_b;
  logic    rf_we;
  logic    dm_we;

  assign s1_go    = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_go;
  assign in_go    = in_valid && !in_stall;

  assign ra_idx   = reg_wrap(in_src_a_reg);
  assign rb_idx   = reg_wrap(in_src_b_reg);
  assign addr_off = in_mem_address - 32'(MEM_BASE);
  assign mem_ok   = (in_mem_address >= 32'(MEM_BASE)) && (addr_off[1:0] == 2'b00) &&
                    (addr_off[31:2] < 30'(MEM_WORDS));
  assign mem_idx  = addr_off[MIDX_W+1:2];

  assign rf_we = s1_go && ex_rf_wr;
  assign dm_we = s1_go && ex_dm_wr;

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_op_r   <= in_operation;
      s1_rd_r   <= reg_wrap(in_dest_reg);
      s1_kind_r <= in_operand_kind;
      s1_imm_r  <= in_immediate;
      s1_addr_r <= in_mem_address;
      s1_mok_r  <= mem_ok;
      s1_midx_r <= mem_idx;
      if (rf_we && s1_rd_r == ra_idx) begin
        s1_a_r <= ex_value;
      end else if (rf_vld_r[ra_idx]) begin
        s1_a_r <= rf_mem[ra_idx];
      end else begin
        s1_a_r <= '0;
      end
      if (rf_we && s1_rd_r == rb_idx) begin
        s1_b_r <= ex_value;
      end else if (rf_vld_r[rb_idx]) begin
        s1_b_r <= rf_mem[rb_idx];
      end else begin
        s1_b_r <= '0;
      end
      if (!mem_ok) begin
        s1_m_r <= '0;
      end else if (dm_we && s1_midx_r == mem_idx) begin
        s1_m_r <= ex_value;
      end else if (dm_vld_r[mem_idx]) begin
        s1_m_r <= dm_mem[mem_idx];
      end else begin
        s1_m_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[s1_rd_r] <= ex_value;
    end
    if (dm_we) begin
      dm_mem[s1_midx_r] <= ex_value;
    end
  end

  always_comb begin
    ex_status = ST_OK;
    ex_value  = '0;
    ex_taken  = 1'b0;
    ex_zf     = zf_r;
    ex_rf_wr  = 1'b0;
    ex_dm_wr  = 1'b0;
    ex_opb    = (s1_kind_r == KIND_REG) ? s1_b_r : s1_imm_r;
    ex_cmp_b  = '0;
    unique case (s1_op_r)
      OP_MOV: begin
        unique case (s1_kind_r)
          KIND_REG: ex_value = s1_b_r;
          KIND_IMM: ex_value = s1_imm_r;
          KIND_MEM: begin
            if (s1_mok_r) ex_value = s1_m_r;
            else ex_status = ST_BAD_ADDR;
          end
          default: ex_status = ST_BAD_KIND;
        endcase
        ex_rf_wr = (ex_status == ST_OK);
      end
      OP_ADD, OP_SUB: begin
        if (s1_kind_r == KIND_REG || s1_kind_r == KIND_IMM) begin
          ex_value = (s1_op_r == OP_ADD) ? s1_a_r + ex_opb : s1_a_r - ex_opb;
          ex_rf_wr = 1'b1;
        end else begin
          ex_status = ST_BAD_KIND;
        end
      end
      OP_AND, OP_OR, OP_XOR: begin
        if (s1_kind_r == KIND_REG) begin
          unique case (s1_op_r)
            OP_AND:  ex_value = s1_a_r & s1_b_r;
            OP_OR:   ex_value = s1_a_r | s1_b_r;
            default: ex_value = s1_a_r ^ s1_b_r;
          endcase
          ex_rf_wr = 1'b1;
        end else begin
          ex_status = ST_BAD_KIND;
        end
      end
      OP_LOAD: begin
        if (s1_mok_r) begin
          ex_value = s1_m_r;
          ex_rf_wr = 1'b1;
        end else begin
          ex_status = ST_BAD_ADDR;
        end
      end
      OP_STORE: begin
        if (s1_mok_r) begin
          ex_value = s1_a_r;
          ex_dm_wr = 1'b1;
        end else begin
          ex_status = ST_BAD_ADDR;
        end
      end
      OP_CMP: begin
        unique case (s1_kind_r)
          KIND_REG: ex_cmp_b = s1_b_r;
          KIND_IMM: ex_cmp_b = s1_imm_r;
          KIND_MEM: ex_cmp_b = s1_addr_r;
          default:  ex_status = ST_BAD_KIND;
        endcase
        if (ex_status == ST_OK) ex_zf = (s1_a_r == ex_cmp_b);
      end
      OP_BEQ: ex_taken = zf_r;
      OP_BNE: ex_taken = !zf_r;
      OP_BAL: ex_taken = 1'b1;
      default: ex_status = ST_BAD_KIND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      zf_r      <= 1'b0;
      rf_vld_r  <= '0;
      dm_vld_r  <= '0;
    end else begin
      s1_vld_r  <= in_go || (s1_vld_r && !s1_go);
      out_vld_r <= s1_go || (out_vld_r && out_stall);
      if (s1_go) zf_r <= ex_zf;
      if (rf_we) rf_vld_r[s1_rd_r] <= 1'b1;
      if (dm_we) dm_vld_r[s1_midx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_status_r <= ex_status;
      out_value_r  <= ex_value;
      out_zf_r     <= ex_zf;
      out_taken_r  <= ex_taken;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_status        = out_status_r;
  assign out_result_value  = out_value_r;
  assign out_zero_flag_out = out_zf_r;
  assign out_branch_taken  = out_taken_r;

endmodule

// ===== hdl/tiex_checker.sv =====
// Port-level checker for the toy ISA execute unit, bound into every unit instance
`include "toy_isa_execute_unit_macros.svh"

module tiex_checker
  import tiex_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_result_value,
  input logic        out_zero_flag_out,
  input logic        out_branch_taken
);

  `TIEX_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_status) && $stable(out_result_value) &&
    $stable(out_zero_flag_out) && $stable(out_branch_taken),
    "result word changed while stalled")
  `TIEX_ASSERT_NOW(a_err_clean, clk, rst_n, out_valid && out_status != ST_OK,
    out_result_value == 32'd0 && !out_branch_taken, "error word carries value or branch")
  `TIEX_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall,
    "input stalled with result side free")
  `TIEX_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n, !out_valid, "result valid straight after reset")

endmodule

bind toy_isa_execute_unit tiex_checker u_tiex_checker (.*);

// ===== tb/tb_toy_isa_execute_unit.sv =====
// Self-checking testbench for the toy ISA execute unit: directed and random instructions
module tb_toy_isa_execute_unit
  import tiex_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_WAIT  = 10;
  localparam word_t       WIN_BASE    = DEF_MEM_BASE;
  localparam int unsigned WIN_WORDS   = DEF_MEM_WORDS;
  localparam int unsigned REG_COUNT   = DEF_NUM_REGS;

  typedef struct {
    op_t      op;
    logic [2:0] rd;
    logic [2:0] ra;
    logic [2:0] rb;
    kind_t    kind;
    word_t    imm;
    word_t    addr;
  } instr_t;

  typedef struct {
    status_t status;
    word_t   value;
    logic    zf;
    logic    taken;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_operation = '0;
  logic [2:0]  in_dest_reg = '0;
  logic [2:0]  in_src_a_reg = '0;
  logic [2:0]  in_src_b_reg = '0;
  logic [1:0]  in_operand_kind = '0;
  logic [31:0] in_immediate = '0;
  logic [31:0] in_mem_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_result_value;
  logic        out_zero_flag_out;
  logic        out_branch_taken;

  word_t    gpr_model [REG_COUNT];
  word_t    dmem_model [WIN_WORDS];
  logic     zf_model;
  outcome_t expected_outcomes [$];
  outcome_t due;

  bit in_idle_en;
  bit out_idle_en;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_rejected;
  int unsigned n_taken;

  toy_isa_execute_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_dest_reg       (in_dest_reg),
    .in_src_a_reg      (in_src_a_reg),
    .in_src_b_reg      (in_src_b_reg),
    .in_operand_kind   (in_operand_kind),
    .in_immediate      (in_immediate),
    .in_mem_address    (in_mem_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_result_value  (out_result_value),
    .out_zero_flag_out (out_zero_flag_out),
    .out_branch_taken  (out_branch_taken)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int mem_slot(word_t a);
    word_t off;
    if (a < WIN_BASE) return -1;
    off = a - WIN_BASE;
    if (off[1:0] != 2'b00) return -1;
    if ((off >> 2) >= WIN_WORDS) return -1;
    return int'(off >> 2);
  endfunction

  // Executes one instruction on the shadow state and returns its result word
  function automatic outcome_t execute_instr(instr_t i);
    outcome_t o;
    int       slot;
    word_t    opb;
    int       rd;
    int       ra;
    int       rb;
    rd = int'(i.rd) % REG_COUNT;
    ra = int'(i.ra) % REG_COUNT;
    rb = int'(i.rb) % REG_COUNT;
    o.status = ST_OK;
    o.value  = '0;
    o.taken  = 1'b0;
    opb      = '0;
    case (i.op)
      OP_MOV: begin
        if (i.kind == KIND_REG) o.value = gpr_model[rb];
        else if (i.kind == KIND_IMM) o.value = i.imm;
        else if (i.kind == KIND_MEM) begin
          slot = mem_slot(i.addr);
          if (slot < 0) o.status = ST_BAD_ADDR;
          else o.value = dmem_model[slot];
        end else o.status = ST_BAD_KIND;
        if (o.status == ST_OK) gpr_model[rd] = o.value;
      end
      OP_ADD, OP_SUB: begin
        if (i.kind == KIND_REG) opb = gpr_model[rb];
        else if (i.kind == KIND_IMM) opb = i.imm;
        else o.status = ST_BAD_KIND;
        if (o.status == ST_OK) begin
          o.value = (i.op == OP_ADD) ? gpr_model[ra] + opb : gpr_model[ra] - opb;
          gpr_model[rd] = o.value;
        end
      end
      OP_AND, OP_OR, OP_XOR: begin
        if (i.kind != KIND_REG) o.status = ST_BAD_KIND;
        else begin
          if (i.op == OP_AND) o.value = gpr_model[ra] & gpr_model[rb];
          else if (i.op == OP_OR) o.value = gpr_model[ra] | gpr_model[rb];
          else o.value = gpr_model[ra] ^ gpr_model[rb];
          gpr_model[rd] = o.value;
        end
      end
      OP_LOAD: begin
        slot = mem_slot(i.addr);
        if (slot < 0) o.status = ST_BAD_ADDR;
        else begin
          o.value = dmem_model[slot];
          gpr_model[rd] = o.value;
        end
      end
      OP_STORE: begin
        slot = mem_slot(i.addr);
        if (slot < 0) o.status = ST_BAD_ADDR;
        else begin
          o.value = gpr_model[ra];
          dmem_model[slot] = o.value;
        end
      end
      OP_CMP: begin
        if (i.kind == KIND_REG) opb = gpr_model[rb];
        else if (i.kind == KIND_IMM) opb = i.imm;
        else if (i.kind == KIND_MEM) opb = i.addr;
        else o.status = ST_BAD_KIND;
        if (o.status == ST_OK) zf_model = (gpr_model[ra] - opb) == '0;
      end
      OP_BEQ: o.taken = zf_model;
      OP_BNE: o.taken = ~zf_model;
      OP_BAL: o.taken = 1'b1;
      default: o.status = ST_BAD_KIND;
    endcase
    if (o.status != ST_OK) begin
      o.value = '0;
      o.taken = 1'b0;
    end
    o.zf = zf_model;
    return o;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sends one instruction word, records its expected result on acceptance
  task automatic send_instr(instr_t i);
    outcome_t o;
    in_valid        <= 1'b1;
    in_operation    <= i.op;
    in_dest_reg     <= i.rd;
    in_src_a_reg    <= i.ra;
    in_src_b_reg    <= i.rb;
    in_operand_kind <= i.kind;
    in_immediate    <= i.imm;
    in_mem_address  <= i.addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    o = execute_instr(i);
    expected_outcomes.push_back(o);
    n_sent++;
    if (o.status != ST_OK) n_rejected++;
    if (o.taken) n_taken++;
    if (in_idle_en && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic instr_t mk(op_t op, logic [2:0] rd, logic [2:0] ra, logic [2:0] rb,
                                kind_t kind, word_t imm, word_t addr);
    instr_t i;
    i.op = op; i.rd = rd; i.ra = ra; i.rb = rb;
    i.kind = kind; i.imm = imm; i.addr = addr;
    return i;
  endfunction

  task automatic compare_field(string name, word_t want, word_t got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        $error("result word with no instruction outstanding");
        fail_count++;
      end else begin
        due = expected_outcomes.pop_front();
        compare_field("status", word_t'(due.status), word_t'(out_status));
        compare_field("result_value", due.value, out_result_value);
        compare_field("zero_flag_out", word_t'(due.zf), word_t'(out_zero_flag_out));
        compare_field("branch_taken", word_t'(due.taken), word_t'(out_branch_taken));
        n_checked++;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (out_idle_en && $urandom_range(0, 99) < 20) begin
        out_stall <= 1'b1;
        repeat (idle_len()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic word_t pick_address();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return WIN_BASE + 4 * $urandom_range(0, WIN_WORDS - 1);
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return WIN_BASE - 4;
        1: return WIN_BASE + 4 * WIN_WORDS;
        2: return WIN_BASE + 4 * $urandom_range(0, WIN_WORDS - 1) + $urandom_range(1, 3);
        default: return WIN_BASE - 1;
      endcase
    end
    return $urandom();
  endfunction

  // Biased towards matching a register so compares land on zero often
  function automatic word_t pick_value(word_t match);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return match;
    if (r < 45) begin
      case ($urandom_range(0, 4))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        3: return 32'h7FFF_FFFF;
        default: return word_t'($urandom_range(0, 15));
      endcase
    end
    return $urandom();
  endfunction

  function automatic instr_t random_instr();
    instr_t i;
    i.op = ($urandom_range(0, 99) < 93) ? op_t'($urandom_range(0, 11))
                                        : op_t'($urandom_range(12, 15));
    i.rd = 3'($urandom_range(0, 7));
    i.ra = 3'($urandom_range(0, 7));
    i.rb = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 88) begin
      case (i.op)
        OP_MOV, OP_CMP: i.kind = kind_t'($urandom_range(0, 2));
        OP_ADD, OP_SUB: i.kind = kind_t'($urandom_range(0, 1));
        OP_AND, OP_OR, OP_XOR: i.kind = KIND_REG;
        default: i.kind = kind_t'($urandom_range(0, 3));
      endcase
    end else begin
      i.kind = kind_t'($urandom_range(0, 3));
    end
    i.imm  = pick_value(gpr_model[int'(i.ra) % REG_COUNT]);
    i.addr = (i.op == OP_CMP && i.kind == KIND_MEM)
             ? pick_value(gpr_model[int'(i.ra) % REG_COUNT]) : pick_address();
    return i;
  endfunction

  task automatic test_reset_values();
    send_instr(mk(OP_LOAD, 3'd1, 3'd0, 3'd0, KIND_REG, '0, WIN_BASE + 32'hC));
    send_instr(mk(OP_BEQ, 3'd0, 3'd0, 3'd0, KIND_IMM, '0, '0));
  endtask

  task automatic test_each_operation();
    send_instr(mk(OP_MOV, 3'd1, 3'd0, 3'd0, KIND_IMM, 32'hFFFF_FFFF, '0));
    send_instr(mk(OP_MOV, 3'd3, 3'd0, 3'd0, KIND_IMM, 32'h8000_0000, '0));
    send_instr(mk(OP_ADD, 3'd4, 3'd1, 3'd0, KIND_IMM, 32'h0000_0001, '0));
    send_instr(mk(OP_SUB, 3'd5, 3'd4, 3'd1, KIND_REG, '0, '0));
    send_instr(mk(OP_AND, 3'd6, 3'd1, 3'd3, KIND_REG, '0, '0));
    send_instr(mk(OP_OR, 3'd7, 3'd3, 3'd5, KIND_REG, '0, '0));
    send_instr(mk(OP_XOR, 3'd0, 3'd1, 3'd3, KIND_REG, '0, '0));
    send_instr(mk(OP_STORE, 3'd0, 3'd1, 3'd0, KIND_REG, '0, WIN_BASE));
    send_instr(mk(OP_STORE, 3'd0, 3'd0, 3'd0, KIND_MEM, '0, WIN_BASE + 4 * (WIN_WORDS - 1)));
    send_instr(mk(OP_LOAD, 3'd2, 3'd0, 3'd0, KIND_IMM, '0, WIN_BASE + 4 * (WIN_WORDS - 1)));
    send_instr(mk(OP_MOV, 3'd4, 3'd0, 3'd0, KIND_MEM, '0, WIN_BASE));
    send_instr(mk(OP_CMP, 3'd0, 3'd4, 3'd1, KIND_REG, '0, '0));
    send_instr(mk(OP_BEQ, 3'd0, 3'd0, 3'd0, KIND_REG, '0, '0));
    send_instr(mk(OP_BNE, 3'd0, 3'd0, 3'd0, KIND_REG, '0, '0));
    send_instr(mk(OP_CMP, 3'd0, 3'd0, 3'd0, KIND_IMM, 32'h0000_0000, '0));
    send_instr(mk(OP_BNE, 3'd0, 3'd0, 3'd0, KIND_REG, '0, '0));
    // memory-kind compare takes the address field as a literal
    send_instr(mk(OP_CMP, 3'd0, 3'd2, 3'd0, KIND_MEM, '0, 32'h7FFF_FFFF));
    send_instr(mk(OP_BAL, 3'd0, 3'd0, 3'd0, KIND_REG, '0, '0));
  endtask

  task automatic test_rejected_instructions();
    send_instr(mk(OP_LOAD, 3'd5, 3'd0, 3'd0, KIND_REG, '0, WIN_BASE - 4));
    send_instr(mk(OP_LOAD, 3'd5, 3'd0, 3'd0, KIND_REG, '0, WIN_BASE + 2));
    send_instr(mk(OP_STORE, 3'd0, 3'd1, 3'd0, KIND_REG, '0, WIN_BASE + 4 * WIN_WORDS));
    send_instr(mk(OP_MOV, 3'd6, 3'd0, 3'd0, KIND_MEM, '0, 32'hFFFF_FFFC));
    send_instr(mk(OP_MOV, 3'd6, 3'd0, 3'd1, 2'd3, 32'h1234_5678, '0));
    send_instr(mk(OP_ADD, 3'd6, 3'd1, 3'd1, KIND_MEM, '0, WIN_BASE));
    send_instr(mk(OP_OR, 3'd6, 3'd1, 3'd1, KIND_IMM, 32'h1, '0));
    send_instr(mk(OP_CMP, 3'd0, 3'd0, 3'd0, 2'd3, '0, '0));
    send_instr(mk(op_t'(4'd12), 3'd7, 3'd7, 3'd7, KIND_REG, 32'hFFFF_FFFF, WIN_BASE));
    send_instr(mk(op_t'(4'd15), 3'd7, 3'd7, 3'd7, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_random_traffic(int unsigned count, bit idle_in, bit idle_out);
    in_idle_en  = idle_in;
    out_idle_en = idle_out;
    repeat (count) send_instr(random_instr());
  endtask

  initial begin
    for (int k = 0; k < REG_COUNT; k++) gpr_model[k] = '0;
    for (int k = 0; k < WIN_WORDS; k++) dmem_model[k] = '0;
    zf_model    = 1'b0;
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_each_operation();
    test_rejected_instructions();
    test_random_traffic(400, 1'b1, 1'b1);
    test_random_traffic(150, 1'b0, 1'b0);
    wait_for_results();
    test_random_traffic(300, 1'b1, 1'b0);
    test_random_traffic(200, 1'b0, 1'b1);

    wait_for_results();
    out_idle_en = 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d instructions over every op code and operand kind; %0d rejected,",
             n_sent, n_rejected);
    $display("%0d branches taken, %0d result words checked under random stalls.",
             n_taken, n_checked);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
